FILE: rtl/rrc_pkg.sv
// Shared types and constants for the rounded-rectangle coverage block.
// Holds the register map, fixed field widths and the corner result struct.
// No dependencies.
`default_nettype none

package rrc_pkg;

   // Configuration port shape
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Fixed register field widths
   localparam int RADII_BITS        = 32;
   localparam int BORDER_BITS       = 32;
   localparam int BORDER_WIDTH_BITS = 8;
   localparam int COLOR_BITS        = 24;

   // Register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOX_X         = 3'd0,
      CSR_BOX_Y         = 3'd1,
      CSR_BOX_WIDTH     = 3'd2,
      CSR_BOX_HEIGHT    = 3'd3,
      CSR_CORNER_RADII  = 3'd4,
      CSR_BORDER_WIDTHS = 3'd5,
      CSR_DRAW_MODE     = 3'd6,
      CSR_PAINT_COLOR   = 3'd7
   } csr_index_type;

   // Draw modes
   localparam logic MODE_FILL   = 1'b0;
   localparam logic MODE_BORDER = 1'b1;

   // Corner indexes into per-corner arrays
   localparam int CORNER_TL = 0;
   localparam int CORNER_TR = 1;
   localparam int CORNER_BL = 2;
   localparam int CORNER_BR = 3;
   localparam int NUM_CORNERS = 4;

   // Per-corner test results
   typedef struct packed {
      logic disk;   // inside the full disk of radius r
      logic arc;    // inside the quadrant ring between inner and outer radius
   } corner_hit_type;

endpackage : rrc_pkg

`default_nettype wire

FILE: rtl/rrc_if.sv
// Valid/ready channel interfaces for the rounded-rectangle coverage block:
// pixel requests, coverage responses and register writes.
// Depends on rrc_pkg.
`default_nettype none

interface rrc_req_if #(parameter int COORD_BITS = 10);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface : rrc_req_if

interface rrc_rsp_if;
   import rrc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  covered;
   logic [COLOR_BITS-1:0] pixel_color;

   modport source (output valid, output covered, output pixel_color, input ready);
   modport sink   (input valid, input covered, input pixel_color, output ready);
endinterface : rrc_rsp_if

interface rrc_csr_if;
   import rrc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : rrc_csr_if

`default_nettype wire

FILE: rtl/rrc_corner.sv
// One corner of the shape: full-disk test for fill mode and quadrant ring
// test for border mode, sharing the offset and squaring logic.
// Depends on rrc_pkg.
`default_nettype none

module rrc_corner #(
   parameter int SW          = 13,
   parameter int RADIUS_BITS = 8,
   parameter int IW          = 8
) (
   input  logic signed [SW-1:0]          px,
   input  logic signed [SW-1:0]          py,
   input  logic signed [SW-1:0]          cx,
   input  logic signed [SW-1:0]          cy,
   input  logic        [RADIUS_BITS-1:0] radius,
   input  logic signed [SW-1:0]          inner_radius,
   input  logic                          left_side,
   input  logic                          top_side,
   output rrc_pkg::corner_hit_type       hit
);
   import rrc_pkg::*;

   localparam int SQ_BITS = 2 * RADIUS_BITS;
   localparam int CW      = 2 * IW + 1;

   typedef logic signed [SW-1:0] sval_type;

   sval_type                 dx, dy, rs, neg_rs;
   sval_type                 adx_full, ady_full, air_full;
   logic [RADIUS_BITS-1:0]   adx, ady;
   logic [IW-1:0]            air;
   logic [SQ_BITS-1:0]       sq_x, sq_y, r_sq;
   logic [SQ_BITS:0]         d2;
   logic [2*IW-1:0]          ir_sq;
   logic                     dx_full, dy_full, dx_quad, dy_quad;
   logic                     inside_outer, outside_inner;

   // Offsets from the corner centre
   assign dx     = px - cx;
   assign dy     = py - cy;
   assign rs     = sval_type'(radius);
   assign neg_rs = -rs;

   // Bounding square of the disk and of the quadrant
   assign dx_full = (dx >= neg_rs) && (dx <= rs);
   assign dy_full = (dy >= neg_rs) && (dy <= rs);
   assign dx_quad = left_side ? ((dx >= neg_rs) && (dx <= sval_type'(0)))
                              : ((dx >= sval_type'(0)) && (dx <= rs));
   assign dy_quad = top_side  ? ((dy >= neg_rs) && (dy <= sval_type'(0)))
                              : ((dy >= sval_type'(0)) && (dy <= rs));

   // Magnitudes; only meaningful once the offset is within the radius
   assign adx_full = dx[SW-1] ? -dx : dx;
   assign ady_full = dy[SW-1] ? -dy : dy;
   assign adx      = adx_full[RADIUS_BITS-1:0];
   assign ady      = ady_full[RADIUS_BITS-1:0];
   assign air_full = inner_radius[SW-1] ? -inner_radius : inner_radius;
   assign air      = air_full[IW-1:0];

   // Squares and distance
   assign sq_x  = adx * adx;
   assign sq_y  = ady * ady;
   assign r_sq  = radius * radius;
   assign ir_sq = air * air;
   assign d2    = {1'b0, sq_x} + {1'b0, sq_y};

   assign inside_outer  = d2 <= {1'b0, r_sq};
   assign outside_inner = CW'(d2) > {1'b0, ir_sq};

   assign hit.disk = dx_full && dy_full && inside_outer;
   assign hit.arc  = dx_quad && dy_quad && inside_outer && outside_inner;

endmodule : rrc_corner

`default_nettype wire

FILE: rtl/rrc_shape.sv
// Coverage decision for one pixel against the configured box: blocks, plus
// bars and disks in fill mode, edge bands and corner arcs in border mode.
// Depends on rrc_pkg and rrc_corner.
`default_nettype none

module rrc_shape #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 8
) (
   input  logic [COORD_BITS-1:0]             pixel_x,
   input  logic [COORD_BITS-1:0]             pixel_y,
   input  logic [COORD_BITS-1:0]             box_x,
   input  logic [COORD_BITS-1:0]             box_y,
   input  logic [COORD_BITS-1:0]             box_width,
   input  logic [COORD_BITS-1:0]             box_height,
   input  logic [rrc_pkg::RADII_BITS-1:0]    corner_radii,
   input  logic [rrc_pkg::BORDER_BITS-1:0]   border_widths,
   input  logic                              draw_mode,
   output logic                              hit
);
   import rrc_pkg::*;

   localparam int MAXB0 = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
   localparam int MAXB  = (MAXB0 > BORDER_WIDTH_BITS) ? MAXB0 : BORDER_WIDTH_BITS;
   localparam int SW    = MAXB + 3;
   localparam int IW    = (RADIUS_BITS > BORDER_WIDTH_BITS) ? RADIUS_BITS
                                                            : BORDER_WIDTH_BITS;
   localparam int RAD_EXT_BITS = NUM_CORNERS * RADIUS_BITS + RADII_BITS;

   typedef logic signed [SW-1:0] sval_type;

   function automatic logic in_span(sval_type v, sval_type lo, sval_type hi_excl);
      return (v >= lo) && (v < hi_excl);
   endfunction

   function automatic logic between(sval_type v, sval_type a, sval_type b);
      return (a <= b) ? ((v >= a) && (v <= b)) : ((v >= b) && (v <= a));
   endfunction

   logic [RAD_EXT_BITS-1:0]  rad_ext;
   logic [RADIUS_BITS-1:0]   rad   [NUM_CORNERS];
   logic                     rad_nz[NUM_CORNERS];
   sval_type                 cx    [NUM_CORNERS];
   sval_type                 cy    [NUM_CORNERS];
   sval_type                 ir    [NUM_CORNERS];
   corner_hit_type           chit  [NUM_CORNERS];
   sval_type                 px, py, x, y, w, h, xr, yb, xe, ye;
   sval_type                 tl, tr, bl, br, left, right, top, bottom;
   sval_type                 wl, wr, wt, wb;
   logic                     fill_hit, border_hit;

   // Unpack corner radii; bits past the register read as zero
   assign rad_ext = RAD_EXT_BITS'(corner_radii);
   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         rad[i]    = rad_ext[i*RADIUS_BITS +: RADIUS_BITS];
         rad_nz[i] = rad[i] != '0;
      end
   end

   // Signed working copies
   assign px = sval_type'(pixel_x);
   assign py = sval_type'(pixel_y);
   assign x  = sval_type'(box_x);
   assign y  = sval_type'(box_y);
   assign w  = sval_type'(box_width);
   assign h  = sval_type'(box_height);
   assign xe = x + w;
   assign ye = y + h;
   assign xr = xe - sval_type'(1);
   assign yb = ye - sval_type'(1);
   assign tl = sval_type'(rad[CORNER_TL]);
   assign tr = sval_type'(rad[CORNER_TR]);
   assign bl = sval_type'(rad[CORNER_BL]);
   assign br = sval_type'(rad[CORNER_BR]);
   assign wl = sval_type'(border_widths[0*BORDER_WIDTH_BITS +: BORDER_WIDTH_BITS]);
   assign wr = sval_type'(border_widths[1*BORDER_WIDTH_BITS +: BORDER_WIDTH_BITS]);
   assign wt = sval_type'(border_widths[2*BORDER_WIDTH_BITS +: BORDER_WIDTH_BITS]);
   assign wb = sval_type'(border_widths[3*BORDER_WIDTH_BITS +: BORDER_WIDTH_BITS]);

   // Corner centres and inner arc radii
   assign cx[CORNER_TL] = x + tl;
   assign cy[CORNER_TL] = y + tl;
   assign cx[CORNER_TR] = xr - tr;
   assign cy[CORNER_TR] = y + tr;
   assign cx[CORNER_BL] = x + bl;
   assign cy[CORNER_BL] = yb - bl;
   assign cx[CORNER_BR] = xr - br;
   assign cy[CORNER_BR] = yb - br;
   assign ir[CORNER_TL] = tl - wt;
   assign ir[CORNER_TR] = tr - wt;
   assign ir[CORNER_BL] = bl - wb;
   assign ir[CORNER_BR] = br - wb;

   for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_corner
      rrc_corner #(
         .SW          (SW),
         .RADIUS_BITS (RADIUS_BITS),
         .IW          (IW)
      ) u_corner (
         .px           (px),
         .py           (py),
         .cx           (cx[g]),
         .cy           (cy[g]),
         .radius       (rad[g]),
         .inner_radius (ir[g]),
         .left_side    ((g == CORNER_TL) || (g == CORNER_BL)),
         .top_side     ((g == CORNER_TL) || (g == CORNER_TR)),
         .hit          (chit[g])
      );
   end

   // Side extents of the corner blocks
   assign left   = (tl > bl) ? tl : bl;
   assign right  = (tr > br) ? tr : br;
   assign top    = (tl > tr) ? tl : tr;
   assign bottom = (bl > br) ? bl : br;

   // Fill: disks or square blocks at the corners, plus the two bars
   always_comb begin
      fill_hit = 1'b0;
      fill_hit |= rad_nz[CORNER_TL] ? chit[CORNER_TL].disk
                  : (in_span(px, x, x + left) && in_span(py, y, y + top));
      fill_hit |= rad_nz[CORNER_TR] ? chit[CORNER_TR].disk
                  : (in_span(px, xe - right, xe) && in_span(py, y, y + top));
      fill_hit |= rad_nz[CORNER_BL] ? chit[CORNER_BL].disk
                  : (in_span(px, x, x + left) && in_span(py, ye - bottom, ye));
      fill_hit |= rad_nz[CORNER_BR] ? chit[CORNER_BR].disk
                  : (in_span(px, xe - right, xe) && in_span(py, ye - bottom, ye));
      fill_hit |= in_span(px, x + left, xe - right) && in_span(py, y, ye);
      fill_hit |= in_span(px, x, xe) && in_span(py, y + top, ye - bottom);
   end

   // Border: left, right, top and bottom edge bands and the arcs of rounded corners
   always_comb begin
      border_hit = 1'b0;
      border_hit |= in_span(px, x, x + wl)   && between(py, y + tl, yb - bl);
      border_hit |= in_span(px, xe - wr, xe) && between(py, y + tr, yb - br);
      border_hit |= in_span(py, y, y + wt)   && between(px, x + tl, xr - tr);
      border_hit |= in_span(py, ye - wb, ye) && between(px, x + bl, xr - br);
      for (int i = 0; i < NUM_CORNERS; i++) begin
         border_hit |= rad_nz[i] && chit[i].arc;
      end
   end

   assign hit = (draw_mode == MODE_BORDER) ? border_hit : fill_hit;

endmodule : rrc_shape

`default_nettype wire

FILE: rtl/rounded_rect_coverage_top.sv
// Rounded-rectangle coverage block: one pixel coordinate in, one coverage
// result out, with the shape held in eight configuration registers.
//
// Channels: req carries pixel_x/pixel_y, rsp returns covered and
// pixel_color (the paint color when covered, zero otherwise), csr writes a
// register by index (0 box_x .. 7 paint_color); csr is always ready.
// Flow: an accepted item loads the pixel register, then the result
// register when it frees. Throughput: one item per cycle while rsp is
// not held off; the coverage logic between the pixel register and the
// result register is one shape evaluation per item.
// Stalls: while rsp is held off, the result register keeps its item and the
// pixel register can still take one more; req.ready drops only when both
// are full and rsp.ready is low.
// Reset: synchronous, zeroes the configuration and empties the pipe.
// Write registers only while no item is in flight.
// Depends on rrc_pkg, rrc_if, rrc_shape and rrc_corner.
`default_nettype none

module rounded_rect_coverage_top #(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   rrc_req_if.sink   req,
   rrc_rsp_if.source rsp,
   rrc_csr_if.sink   csr
);
   import rrc_pkg::*;

   // Configuration registers
   logic [COORD_BITS-1:0]  box_x_ff, box_y_ff, box_width_ff, box_height_ff;
   logic [RADII_BITS-1:0]  corner_radii_ff;
   logic [BORDER_BITS-1:0] border_widths_ff;
   logic                   draw_mode_ff;
   logic [COLOR_BITS-1:0]  paint_color_ff;

   // Pipeline
   logic                   s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0]  s1_x_ff, s1_y_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   covered_ff;
   logic [COLOR_BITS-1:0]  color_ff;
   logic                   advance, req_take, shape_hit;

   // Register writes
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff         <= '0;
         box_y_ff         <= '0;
         box_width_ff     <= '0;
         box_height_ff    <= '0;
         corner_radii_ff  <= '0;
         border_widths_ff <= '0;
         draw_mode_ff     <= MODE_FILL;
         paint_color_ff   <= '0;
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_BOX_X:         box_x_ff         <= csr.data[COORD_BITS-1:0];
            CSR_BOX_Y:         box_y_ff         <= csr.data[COORD_BITS-1:0];
            CSR_BOX_WIDTH:     box_width_ff     <= csr.data[COORD_BITS-1:0];
            CSR_BOX_HEIGHT:    box_height_ff    <= csr.data[COORD_BITS-1:0];
            CSR_CORNER_RADII:  corner_radii_ff  <= csr.data[RADII_BITS-1:0];
            CSR_BORDER_WIDTHS: border_widths_ff <= csr.data[BORDER_BITS-1:0];
            CSR_DRAW_MODE:     draw_mode_ff     <= csr.data[0];
            CSR_PAINT_COLOR:   paint_color_ff   <= csr.data[COLOR_BITS-1:0];
         endcase
      end
   end

   // Handshake: result register frees when empty or taken
   assign advance      = !out_valid_ff || rsp.ready;
   assign req.ready    = !s1_valid_ff || advance;
   assign req_take     = req.valid && req.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the pixel
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_x_ff <= req.pixel_x;
         s1_y_ff <= req.pixel_y;
      end
   end

   rrc_shape #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_shape (
      .pixel_x       (s1_x_ff),
      .pixel_y       (s1_y_ff),
      .box_x         (box_x_ff),
      .box_y         (box_y_ff),
      .box_width     (box_width_ff),
      .box_height    (box_height_ff),
      .corner_radii  (corner_radii_ff),
      .border_widths (border_widths_ff),
      .draw_mode     (draw_mode_ff),
      .hit           (shape_hit)
   );

   // Load the result when the item moves on
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         covered_ff <= shape_hit;
         color_ff   <= shape_hit ? paint_color_ff : '0;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.covered     = covered_ff;
   assign rsp.pixel_color = color_ff;

   // Checks
   a_empty_pipe_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !out_valid_ff) |-> req.ready)
      else $error("input stalled with an empty pipeline");

   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item did not reach the pixel register");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> (out_valid_ff && $stable(covered_ff)))
      else $error("stalled result lost or changed");

   a_uncovered_black: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !covered_ff) |-> (color_ff == '0))
      else $error("color present on an uncovered pixel");

   a_s1_moves_on: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> out_valid_ff)
      else $error("pixel register item did not reach the result register");

endmodule : rounded_rect_coverage_top

`default_nettype wire
